[rtl/scaled_glyph_blitter_two_plane_assert.svh]
// assertion macros for the glyph blitter
`ifndef SCALED_GLYPH_BLITTER_TWO_PLANE_ASSERT_SVH
`define SCALED_GLYPH_BLITTER_TWO_PLANE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SGB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgb assertion failed");

// next-cycle implication, disabled in reset
`define SGB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgb assertion failed");

`endif

[rtl/sgb_pkg.sv]
package sgb_pkg;

  typedef enum logic [1:0] {
    ACT_DRAW  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_DRAW_RD,
    ST_DRAW_WR
  } state_t;

  localparam logic [1:0] INK_BLACK = 2'd0;
  localparam logic [1:0] INK_RED   = 2'd2;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam logic [7:0] LEFT_BIT = 8'h80;
  // origin is 16 bits, glyph spans at most 5*15 by 7*15 pixels (4-bit zoom)
  localparam int COORD_W = 18;

  typedef struct packed {
    logic load;
    logic host_rd;
    logic host_wr;
    logic pix_rd;
    logic pix_wr;
    logic step;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    addr_ok;
    logic    zoom_zero;
    logic    pix_ok;
    logic    last_pix;
  } sts_t;

endpackage

[rtl/sgb_ram.sv]
module sgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4000
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sgb_ctrl.sv]
module sgb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sgb_pkg::sts_t sts,
  output logic          busy,
  output sgb_pkg::cmd_t cmd
);
  import sgb_pkg::*;

  `include "scaled_glyph_blitter_two_plane_assert.svh"

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (sts.act)
            ACT_DRAW: begin
              if (!sts.zoom_zero) state_nxt = ST_DRAW_RD;
            end
            ACT_READ: state_nxt = ST_RD_WAIT;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD_WAIT: state_nxt = ST_IDLE;
      ST_DRAW_RD: begin
        if (sts.pix_ok) begin
          state_nxt = ST_DRAW_WR;
        end else if (sts.last_pix) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAW_WR: begin
        state_nxt = sts.last_pix ? ST_IDLE : ST_DRAW_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (sts.act)
            ACT_DRAW:  cmd.load    = !sts.zoom_zero;
            ACT_WRITE: cmd.host_wr = sts.addr_ok;
            ACT_READ:  cmd.host_rd = 1'b1;
            default:   cmd         = '0;
          endcase
        end
      end
      ST_RD_WAIT: cmd.out_valid = 1'b1;
      ST_DRAW_RD: begin
        cmd.pix_rd = sts.pix_ok;
        cmd.step   = !sts.pix_ok;
      end
      ST_DRAW_WR: begin
        cmd.pix_wr = 1'b1;
        cmd.step   = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  `SGB_ASSERT_NOW(a_out_after_read, cmd.out_valid, $past(cmd.host_rd))
  `SGB_ASSERT_NEXT(a_rd_then_wr, cmd.pix_rd, cmd.pix_wr)
  `SGB_ASSERT_NOW(a_host_only_idle, cmd.host_wr || cmd.host_rd || cmd.load, !busy)

endmodule

[rtl/sgb_dp.sv]
module sgb_dp #(
  parameter int PANEL_WIDTH  = 122,
  parameter int PANEL_HEIGHT = 250,
  parameter int ROW_BYTES    = 16,
  parameter int MAX_ZOOM     = 8
) (
  input  logic                clk,
  input  logic [1:0]          in_action,
  input  logic signed [15:0]  in_origin_x,
  input  logic signed [15:0]  in_origin_y,
  input  logic [34:0]         in_glyph_bits,
  input  logic [1:0]          in_ink,
  input  logic [3:0]          in_zoom,
  input  logic [11:0]         in_byte_addr,
  input  logic [7:0]          in_bw_wdata,
  input  logic [7:0]          in_red_wdata,
  input  sgb_pkg::cmd_t       cmd,
  output sgb_pkg::sts_t       sts,
  output logic [7:0]          out_bw_rdata,
  output logic [7:0]          out_red_rdata
);
  import sgb_pkg::*;

  localparam int PLANE_BYTES = PANEL_HEIGHT * ROW_BYTES;
  localparam int AW   = $clog2(PLANE_BYTES);
  localparam int ZW   = $clog2(MAX_ZOOM + 1);
  localparam int XB   = $clog2(PANEL_WIDTH) + 1;
  localparam int PY_W = $clog2(PANEL_HEIGHT);
  localparam int IW   = $clog2(PLANE_BYTES + 2 ** (XB - 3));

  localparam logic signed [COORD_W-1:0] PW_S = COORD_W'(PANEL_WIDTH);
  localparam logic signed [COORD_W-1:0] PH_S = COORD_W'(PANEL_HEIGHT);

  logic signed [COORD_W-1:0] px_r, py_r, oy_r;
  logic [34:0]   glyph_r;
  logic [1:0]    ink_r;
  logic [ZW-1:0] zoom_r, sx_r, sy_r;
  logic [2:0]    cx_r, cy_r;
  logic          rd_ok_r;

  logic [ZW-1:0] zoom_sat, z_last;
  logic          sy_wrap, cy_wrap, sx_wrap;
  logic          px_ok, py_ok;
  logic [IW-1:0] idx_w;
  logic [AW-1:0] pix_idx;
  logic [5:0]    bit_idx;
  logic          fg;
  logic [7:0]    mask;
  logic [7:0]    bw_q, red_q, bw_new, red_new;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_bw_wd, ram_red_wd;

  // zoom above the maximum saturates
  assign zoom_sat = (5'(in_zoom) > 5'(MAX_ZOOM)) ? ZW'(MAX_ZOOM) : ZW'(in_zoom);
  assign z_last   = zoom_r - ZW'(1);
  assign sy_wrap  = (sy_r == z_last);
  assign cy_wrap  = sy_wrap && (cy_r == 3'(GLYPH_ROWS - 1));
  assign sx_wrap  = cy_wrap && (sx_r == z_last);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r    <= COORD_W'(in_origin_x);
      py_r    <= COORD_W'(in_origin_y);
      oy_r    <= COORD_W'(in_origin_y);
      glyph_r <= in_glyph_bits;
      ink_r   <= in_ink;
      zoom_r  <= zoom_sat;
      sx_r    <= '0;
      sy_r    <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
    end else if (cmd.step) begin
      // rows innermost, then replicated columns, then glyph columns
      if (cy_wrap) begin
        py_r <= oy_r;
        cy_r <= '0;
        sy_r <= '0;
        px_r <= px_r + COORD_W'(1);
        if (sx_wrap) begin
          sx_r <= '0;
          cx_r <= cx_r + 3'd1;
        end else begin
          sx_r <= sx_r + ZW'(1);
        end
      end else begin
        py_r <= py_r + COORD_W'(1);
        if (sy_wrap) begin
          sy_r <= '0;
          cy_r <= cy_r + 3'd1;
        end else begin
          sy_r <= sy_r + ZW'(1);
        end
      end
    end
    if (cmd.host_rd) begin
      rd_ok_r <= sts.addr_ok;
    end
  end

  assign px_ok   = (px_r >= 0) && (px_r < PW_S);
  assign py_ok   = (py_r >= 0) && (py_r < PH_S);
  assign idx_w   = IW'(py_r[PY_W-1:0]) * IW'(ROW_BYTES) + IW'(px_r[XB-1:3]);
  assign pix_idx = idx_w[AW-1:0];
  assign bit_idx = 6'(cx_r) * 6'(GLYPH_ROWS) + 6'(cy_r);
  assign fg      = glyph_r[bit_idx];
  assign mask    = LEFT_BIT >> px_r[2:0];

  always_comb begin
    if (fg && ink_r == INK_BLACK) begin
      bw_new  = bw_q & ~mask;
      red_new = red_q & ~mask;
    end else if (fg && ink_r == INK_RED) begin
      bw_new  = bw_q | mask;
      red_new = red_q | mask;
    end else begin
      bw_new  = bw_q | mask;
      red_new = red_q & ~mask;
    end
  end

  assign ram_we     = cmd.host_wr || cmd.pix_wr;
  assign ram_waddr  = cmd.host_wr ? AW'(in_byte_addr) : pix_idx;
  assign ram_raddr  = cmd.host_rd ? AW'(in_byte_addr) : pix_idx;
  assign ram_bw_wd  = cmd.host_wr ? in_bw_wdata : bw_new;
  assign ram_red_wd = cmd.host_wr ? in_red_wdata : red_new;

  sgb_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_bw_plane (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_bw_wd),
    .raddr (ram_raddr),
    .rdata (bw_q)
  );

  sgb_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_red_plane (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_red_wd),
    .raddr (ram_raddr),
    .rdata (red_q)
  );

  assign out_bw_rdata  = rd_ok_r ? bw_q : 8'd0;
  assign out_red_rdata = rd_ok_r ? red_q : 8'd0;

  always_comb begin
    sts.act       = action_t'(in_action);
    sts.addr_ok   = 32'(in_byte_addr) < PLANE_BYTES;
    sts.zoom_zero = (in_zoom == 4'd0);
    sts.pix_ok    = px_ok && py_ok && (idx_w < IW'(PLANE_BYTES));
    sts.last_pix  = sx_wrap && (cx_r == 3'(GLYPH_COLS - 1));
  end

endmodule

[rtl/scaled_glyph_blitter_two_plane.sv]
// read word: result strobes in the cycle after start is taken; write: takes effect at accept
// draw word: 35*z*z pixels (z = zoom, capped at MAX_ZOOM), each on-panel pixel done by one
// read-modify-write on the planes (one read and one write port each); clipped pixels are skipped
// zoom 0 finishes at accept
// synchronous active-low reset returns the controller to idle; plane contents are not cleared
module scaled_glyph_blitter_two_plane #(
  parameter int PANEL_WIDTH  = 122,
  parameter int PANEL_HEIGHT = 250,
  parameter int ROW_BYTES    = 16,
  parameter int MAX_ZOOM     = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // input word, taken when start is high and busy is low
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic [34:0]        in_glyph_bits,
  input  logic [1:0]         in_ink,
  input  logic [3:0]         in_zoom,
  input  logic [11:0]        in_byte_addr,
  input  logic [7:0]         in_bw_wdata,
  input  logic [7:0]         in_red_wdata,
  // result word, valid for exactly one cycle
  output logic               out_valid,
  output logic [7:0]         out_bw_rdata,
  output logic [7:0]         out_red_rdata
);
  import sgb_pkg::*;

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // controller: idle, read wait, pixel read, pixel write
  sgb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath: pixel walk counters, clipping, byte index, both plane rams
  sgb_dp #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .ROW_BYTES    (ROW_BYTES),
    .MAX_ZOOM     (MAX_ZOOM)
  ) u_dp (
    .clk           (clk),
    .in_action     (in_action),
    .in_origin_x   (in_origin_x),
    .in_origin_y   (in_origin_y),
    .in_glyph_bits (in_glyph_bits),
    .in_ink        (in_ink),
    .in_zoom       (in_zoom),
    .in_byte_addr  (in_byte_addr),
    .in_bw_wdata   (in_bw_wdata),
    .in_red_wdata  (in_red_wdata),
    .cmd           (cmd),
    .sts           (sts),
    .out_bw_rdata  (out_bw_rdata),
    .out_red_rdata (out_red_rdata)
  );

  // strobe comes straight from the read wait state
  assign out_valid = cmd.out_valid;

endmodule
